FILE: hdl/frpt_pkg.sv
// Package for the frame packet reassembly tracker.
// Holds result types, ack codes, register indexes and reset constants.
// No dependencies.
`default_nettype none

package frpt_pkg;

  typedef enum logic [1:0] {
    ACK_FRAGMENT = 2'd0,
    ACK_COMPLETE = 2'd1,
    ACK_DROPPED  = 2'd2
  } ack_kind_t;

  localparam int CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ASSEMBLY_TIMEOUT = 1'd0;
  localparam cfg_idx_t CFG_RESTART_TIMEOUT  = 1'd1;

  localparam logic [15:0] ASSEMBLY_TIMEOUT_RST = 16'd40;
  localparam logic [15:0] RESTART_TIMEOUT_RST  = 16'd120;
  localparam logic [15:0] NEWER_LIMIT          = 16'h8000;
  localparam logic [15:0] AGE_MAX              = 16'hFFFF;

  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;
  localparam logic [RES_CNT_W-1:0] RES_ROOM_LIMIT = 3'd2;

  typedef struct packed {
    ack_kind_t   ack_kind;
    logic [15:0] ack_frame;
    logic [2:0]  ack_fragment;
    logic [3:0]  received_count;
    logic        write_payload;
    logic        commit_frame;
    logic        commit_limit;
    logic [7:0]  commit_brightness;
    logic        last;
  } result_t;

  function automatic logic is_newer(logic [15:0] cand, logic [15:0] ref_fr);
    logic [15:0] d;
    d = cand - ref_fr;
    return (d != 16'd0) && (d < NEWER_LIMIT);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/frame_packet_reassembly_tracker_core.sv
// Frame packet reassembly tracker, top level.
// Depends on frpt_pkg (types, ack codes, register indexes).
// Single module: tracker state, decision logic and a 4-entry result queue.
`default_nettype none

// Usage: one input beat (packet or millisecond tick) is taken per clock.
// The tracker state is updated at the accepting edge and the beat's results
// (none, one, or two for the fragment that finishes a frame) go into a
// 4-entry result queue; the first result can leave on the next cycle. The
// result port moves one beat per cycle unless out_stall holds it, and a
// completing fragment sends two. in_stall is raised while more than two
// results are queued, which happens when the result side stalls or when
// completing fragments come in faster than one result per cycle can drain.
// Configuration writes are always ready and take effect on the next beat.
module frame_packet_reassembly_tracker_core #(
  parameter int FRAGMENTS = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire frpt_pkg::cfg_idx_t    cfg_index,
  input  wire logic [15:0]           cfg_data,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire logic                  in_packet_ok,
  input  wire logic [31:0]           in_source_addr,
  input  wire logic [15:0]           in_source_port,
  input  wire logic [15:0]           in_frame_number,
  input  wire logic [2:0]            in_fragment_index,
  input  wire logic                  in_limit_flag,
  input  wire logic [7:0]            in_brightness,
  input  wire logic                  in_commit_ok,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_ack_kind,
  output logic [15:0]                out_ack_frame,
  output logic [2:0]                 out_ack_fragment,
  output logic [3:0]                 out_received_count,
  output logic                       out_write_payload,
  output logic                       out_commit_frame,
  output logic                       out_commit_limit,
  output logic [7:0]                 out_commit_brightness,
  output logic                       out_last
);
  import frpt_pkg::*;

  localparam logic [3:0] FRAG_CNT = 4'(FRAGMENTS);

  logic [15:0] asm_timeout_r, asm_timeout_nxt;
  logic [15:0] rst_timeout_r, rst_timeout_nxt;

  logic                 assembling_r, assembling_nxt;
  logic [15:0]          cur_frame_r, cur_frame_nxt;
  logic [31:0]          cur_addr_r, cur_addr_nxt;
  logic [15:0]          cur_port_r, cur_port_nxt;
  logic                 cur_limit_r, cur_limit_nxt;
  logic [7:0]           cur_bright_r, cur_bright_nxt;
  logic [FRAGMENTS-1:0] got_mask_r, got_mask_nxt;
  logic [3:0]           got_count_r, got_count_nxt;
  logic [15:0]          frame_age_r, frame_age_nxt;
  logic                 had_complete_r, had_complete_nxt;
  logic [15:0]          done_frame_r, done_frame_nxt;
  logic [31:0]          prev_addr_r, prev_addr_nxt;
  logic [15:0]          prev_port_r, prev_port_nxt;
  logic                 prev_valid_r, prev_valid_nxt;
  logic [15:0]          since_complete_r, since_complete_nxt;

  result_t              res_q_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;

  logic                 in_fire, out_fire, cfg_fire;
  logic                 push0, push1;
  result_t              res0, res1;

  // decision terms
  logic                 pkt_valid, src_changed, restarted, same_sender;
  logic                 start, reject;
  logic                 eff_limit;
  logic [7:0]           eff_bright;
  logic [FRAGMENTS-1:0] eff_mask, frag_bit, mask_new;
  logic [3:0]           eff_count, count_new;
  result_t              out_res;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = res_cnt_r > RES_ROOM_LIMIT;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = res_cnt_r != '0;
  assign out_fire  = out_valid && !out_stall;

  always_comb begin
    asm_timeout_nxt    = asm_timeout_r;
    rst_timeout_nxt    = rst_timeout_r;
    assembling_nxt     = assembling_r;
    cur_frame_nxt      = cur_frame_r;
    cur_addr_nxt       = cur_addr_r;
    cur_port_nxt       = cur_port_r;
    cur_limit_nxt      = cur_limit_r;
    cur_bright_nxt     = cur_bright_r;
    got_mask_nxt       = got_mask_r;
    got_count_nxt      = got_count_r;
    frame_age_nxt      = frame_age_r;
    had_complete_nxt   = had_complete_r;
    done_frame_nxt     = done_frame_r;
    prev_addr_nxt      = prev_addr_r;
    prev_port_nxt      = prev_port_r;
    prev_valid_nxt     = prev_valid_r;
    since_complete_nxt = since_complete_r;
    push0              = 1'b0;
    push1              = 1'b0;

    pkt_valid   = in_packet_ok && ({1'b0, in_fragment_index} < FRAG_CNT);
    same_sender = (cur_addr_r == in_source_addr) && (cur_port_r == in_source_port);
    src_changed = !(prev_valid_r && (prev_addr_r == in_source_addr) &&
                    (prev_port_r == in_source_port));
    restarted   = had_complete_r && (since_complete_r >= rst_timeout_r);
    start       = 1'b0;
    reject      = 1'b0;
    if (!assembling_r) begin
      if (had_complete_r && !src_changed && !restarted &&
          !is_newer(in_frame_number, done_frame_r)) begin
        reject = 1'b1;
      end else begin
        start = 1'b1;
      end
    end else if (!same_sender) begin
      start = 1'b1;
    end else if (in_frame_number != cur_frame_r) begin
      if (!is_newer(in_frame_number, cur_frame_r)) begin
        reject = 1'b1;
      end else begin
        start = 1'b1;
      end
    end

    eff_limit  = start ? in_limit_flag : cur_limit_r;
    eff_bright = start ? in_brightness : cur_bright_r;
    eff_mask   = start ? '0 : got_mask_r;
    eff_count  = start ? 4'd0 : got_count_r;
    frag_bit   = FRAGMENTS'(1) << in_fragment_index;
    mask_new   = eff_mask | frag_bit;
    count_new  = eff_count + 4'd1;

    res0.ack_kind          = ACK_FRAGMENT;
    res0.ack_frame         = in_frame_number;
    res0.ack_fragment      = in_fragment_index;
    res0.received_count    = count_new;
    res0.write_payload     = 1'b1;
    res0.commit_frame      = 1'b0;
    res0.commit_limit      = 1'b0;
    res0.commit_brightness = 8'd0;
    res0.last              = 1'b1;

    res1.ack_kind          = in_commit_ok ? ACK_COMPLETE : ACK_DROPPED;
    res1.ack_frame         = in_frame_number;
    res1.ack_fragment      = in_fragment_index;
    res1.received_count    = FRAG_CNT;
    res1.write_payload     = 1'b0;
    res1.commit_frame      = in_commit_ok;
    res1.commit_limit      = in_commit_ok ? eff_limit : 1'b0;
    res1.commit_brightness = in_commit_ok ? eff_bright : 8'd0;
    res1.last              = 1'b1;

    if (cfg_fire) begin
      case (cfg_index)
        CFG_ASSEMBLY_TIMEOUT: asm_timeout_nxt = cfg_data;
        CFG_RESTART_TIMEOUT:  rst_timeout_nxt = cfg_data;
        default: ;
      endcase
    end

    if (in_fire) begin
      if (in_mode == MODE_TICK) begin
        if (assembling_r && (frame_age_r != AGE_MAX)) begin
          frame_age_nxt = frame_age_r + 16'd1;
        end
        if (since_complete_r != AGE_MAX) begin
          since_complete_nxt = since_complete_r + 16'd1;
        end
      end else if (pkt_valid && !reject) begin
        if (start) begin
          assembling_nxt = 1'b1;
          cur_frame_nxt  = in_frame_number;
          cur_addr_nxt   = in_source_addr;
          cur_port_nxt   = in_source_port;
          cur_limit_nxt  = in_limit_flag;
          cur_bright_nxt = in_brightness;
          got_mask_nxt   = '0;
          got_count_nxt  = 4'd0;
          frame_age_nxt  = 16'd0;
        end
        if ((in_limit_flag != eff_limit) || (in_brightness != eff_bright)) begin
          assembling_nxt = 1'b0;
        end else if ((eff_mask & frag_bit) == '0) begin
          got_mask_nxt  = mask_new;
          got_count_nxt = count_new;
          push0         = 1'b1;
          if (&mask_new) begin
            res0.last      = 1'b0;
            push1          = 1'b1;
            assembling_nxt = 1'b0;
            if (in_commit_ok) begin
              done_frame_nxt     = in_frame_number;
              since_complete_nxt = 16'd0;
              had_complete_nxt   = 1'b1;
              prev_addr_nxt      = start ? in_source_addr : cur_addr_r;
              prev_port_nxt      = start ? in_source_port : cur_port_r;
              prev_valid_nxt     = 1'b1;
            end
          end
        end
      end
      if (assembling_nxt && (frame_age_nxt > asm_timeout_r)) begin
        assembling_nxt = 1'b0;
      end
    end

    wr_ptr_nxt  = wr_ptr_r + RES_PTR_W'(push0) + RES_PTR_W'(push1);
    rd_ptr_nxt  = rd_ptr_r + RES_PTR_W'(out_fire);
    res_cnt_nxt = res_cnt_r + RES_CNT_W'(push0) + RES_CNT_W'(push1)
                  - RES_CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_timeout_r    <= ASSEMBLY_TIMEOUT_RST;
      rst_timeout_r    <= RESTART_TIMEOUT_RST;
      assembling_r     <= 1'b0;
      cur_frame_r      <= '0;
      cur_addr_r       <= '0;
      cur_port_r       <= '0;
      cur_limit_r      <= 1'b0;
      cur_bright_r     <= '0;
      got_mask_r       <= '0;
      got_count_r      <= '0;
      frame_age_r      <= '0;
      had_complete_r   <= 1'b0;
      done_frame_r     <= '0;
      prev_addr_r      <= '0;
      prev_port_r      <= '0;
      prev_valid_r     <= 1'b0;
      since_complete_r <= '0;
      wr_ptr_r         <= '0;
      rd_ptr_r         <= '0;
      res_cnt_r        <= '0;
    end else begin
      asm_timeout_r    <= asm_timeout_nxt;
      rst_timeout_r    <= rst_timeout_nxt;
      assembling_r     <= assembling_nxt;
      cur_frame_r      <= cur_frame_nxt;
      cur_addr_r       <= cur_addr_nxt;
      cur_port_r       <= cur_port_nxt;
      cur_limit_r      <= cur_limit_nxt;
      cur_bright_r     <= cur_bright_nxt;
      got_mask_r       <= got_mask_nxt;
      got_count_r      <= got_count_nxt;
      frame_age_r      <= frame_age_nxt;
      had_complete_r   <= had_complete_nxt;
      done_frame_r     <= done_frame_nxt;
      prev_addr_r      <= prev_addr_nxt;
      prev_port_r      <= prev_port_nxt;
      prev_valid_r     <= prev_valid_nxt;
      since_complete_r <= since_complete_nxt;
      wr_ptr_r         <= wr_ptr_nxt;
      rd_ptr_r         <= rd_ptr_nxt;
      res_cnt_r        <= res_cnt_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push0) begin
      res_q_r[wr_ptr_r] <= res0;
    end
    if (push1) begin
      res_q_r[wr_ptr_r + RES_PTR_W'(1)] <= res1;
    end
  end

  assign out_res               = res_q_r[rd_ptr_r];
  assign out_ack_kind          = out_res.ack_kind;
  assign out_ack_frame         = out_res.ack_frame;
  assign out_ack_fragment      = out_res.ack_fragment;
  assign out_received_count    = out_res.received_count;
  assign out_write_payload     = out_res.write_payload;
  assign out_commit_frame      = out_res.commit_frame;
  assign out_commit_limit      = out_res.commit_limit;
  assign out_commit_brightness = out_res.commit_brightness;
  assign out_last              = out_res.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  a_count_mask: assert property (@(posedge clk) disable iff (!rst_n)
    got_count_r == 4'($countones(got_mask_r)))
    else $error("fragment count disagrees with mask");

  a_building_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    assembling_r |-> (got_count_r < FRAG_CNT))
    else $error("full frame still being built");

  a_commit_clears_age: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_mode == MODE_PACKET) && push1 && in_commit_ok)
      |=> (since_complete_r == 16'd0) && had_complete_r && !assembling_r)
    else $error("commit did not update completion state");

endmodule

`default_nettype wire

FILE: sim/frame_packet_reassembly_tracker_core_test.sv
// Self-checking testbench for frame_packet_reassembly_tracker_core.
// A directed table and random frame traffic are checked against an in-bench tracker model.
// Depends on frpt_pkg and the core RTL only.
module frame_packet_reassembly_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import frpt_pkg::*;

  localparam int FRAGS = 2;
  localparam int RAND_PER_PHASE = 60;
  localparam int NUM_PHASES = 9;
  localparam int SETTLE = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS = 23;
  localparam logic [31:0] ADDR_HI = 32'hFFFF_FFFF;
  localparam logic [15:0] PORT_HI = 16'hFFFF;

  typedef struct packed {
    logic        mode;
    logic        ok;
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] frame;
    logic [2:0]  frag;
    logic        lim;
    logic [7:0]  bright;
    logic        commit;
  } beat_t;

  typedef struct {
    beat_t     beat;
    bit        typed;
    int        n;
    ack_kind_t kind;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic        in_packet_ok;
  logic [31:0] in_source_addr;
  logic [15:0] in_source_port;
  logic [15:0] in_frame_number;
  logic [2:0]  in_fragment_index;
  logic        in_limit_flag;
  logic [7:0]  in_brightness;
  logic        in_commit_ok;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_ack_kind;
  logic [15:0] out_ack_frame;
  logic [2:0]  out_ack_fragment;
  logic [3:0]  out_received_count;
  logic        out_write_payload;
  logic        out_commit_frame;
  logic        out_commit_limit;
  logic [7:0]  out_commit_brightness;
  logic        out_last;

  frame_packet_reassembly_tracker_core #(.FRAGMENTS(FRAGS)) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_mode               (in_mode),
    .in_packet_ok          (in_packet_ok),
    .in_source_addr        (in_source_addr),
    .in_source_port        (in_source_port),
    .in_frame_number       (in_frame_number),
    .in_fragment_index     (in_fragment_index),
    .in_limit_flag         (in_limit_flag),
    .in_brightness         (in_brightness),
    .in_commit_ok          (in_commit_ok),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_ack_kind          (out_ack_kind),
    .out_ack_frame         (out_ack_frame),
    .out_ack_fragment      (out_ack_fragment),
    .out_received_count    (out_received_count),
    .out_write_payload     (out_write_payload),
    .out_commit_frame      (out_commit_frame),
    .out_commit_limit      (out_commit_limit),
    .out_commit_brightness (out_commit_brightness),
    .out_last              (out_last)
  );

  // mode, ok, addr, port, frame, frag, lim, bright, commit
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{'{MODE_TICK,   1'b1, ADDR_HI, PORT_HI, 16'hFFFF, 3'd7, 1'b1, 8'hFF, 1'b1}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b0, ADDR_HI, PORT_HI, 16'h0005, 3'd0, 1'b1, 8'hFF, 1'b1}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'h0000, 3'd7, 1'b1, 8'hFF, 1'b1}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'h0000, 3'd0, 1'b1, 8'hFF, 1'b1}, 1, 1, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'h0000, 3'd0, 1'b1, 8'hFF, 1'b1}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'h0000, 3'd1, 1'b1, 8'hFF, 1'b1}, 1, 2, ACK_COMPLETE},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'h0000, 3'd0, 1'b1, 8'hFF, 1'b1}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'hFFFF, 3'd0, 1'b1, 8'hFF, 1'b1}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'h8000, 3'd0, 1'b1, 8'hFF, 1'b1}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'h7FFF, 3'd0, 1'b1, 8'hFF, 1'b1}, 1, 1, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'h7FFF, 3'd1, 1'b0, 8'hFF, 1'b1}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'h7FFF, 3'd1, 1'b1, 8'hFF, 1'b1}, 1, 1, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'h7FFE, 3'd0, 1'b1, 8'hFF, 1'b1}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, ADDR_HI, PORT_HI, 16'h7FFF, 3'd0, 1'b1, 8'h00, 1'b1}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, 32'h0, 16'h0000, 16'h0000, 3'd1, 1'b0, 8'h00, 1'b0}, 1, 1, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, 32'h0, 16'h0001, 16'h0003, 3'd0, 1'b0, 8'h00, 1'b0}, 1, 1, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, 32'h0, 16'h0001, 16'h0004, 3'd1, 1'b0, 8'h00, 1'b0}, 1, 1, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, 32'h0, 16'h0001, 16'h0004, 3'd0, 1'b0, 8'h00, 1'b0}, 1, 2, ACK_DROPPED},
    '{'{MODE_PACKET, 1'b1, 32'h0, 16'h0001, 16'h0004, 3'd0, 1'b0, 8'h00, 1'b1}, 0, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, 32'h0, 16'h0001, 16'h0004, 3'd1, 1'b0, 8'h00, 1'b1}, 1, 2, ACK_COMPLETE},
    '{'{MODE_TICK,   1'b0, 32'h0, 16'h0000, 16'h0000, 3'd0, 1'b0, 8'h00, 1'b0}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, 32'h0, 16'h0001, 16'h8004, 3'd0, 1'b0, 8'h00, 1'b1}, 1, 0, ACK_FRAGMENT},
    '{'{MODE_PACKET, 1'b1, 32'h0, 16'h0001, 16'h8003, 3'd0, 1'b0, 8'h00, 1'b1}, 1, 1, ACK_FRAGMENT}
  };

  result_t acks_due[$];
  int      mismatches = 0;
  int      cycle_cnt = 0;
  int      burst_left = 0;
  int      stall_left = 0;
  int      stall_mode = 0;

  // tracker model state
  logic [15:0]      asm_limit;
  logic [15:0]      rst_limit;
  logic             bld_active;
  logic [15:0]      bld_frame;
  logic [31:0]      bld_addr;
  logic [15:0]      bld_port;
  logic             bld_lim;
  logic [7:0]       bld_bright;
  logic [FRAGS-1:0] bld_mask;
  logic [3:0]       bld_count;
  logic [15:0]      bld_age;
  logic             has_done;
  logic [15:0]      done_frame;
  logic [31:0]      done_addr;
  logic [15:0]      done_port;
  logic             done_valid;
  logic [15:0]      idle_ticks;

  // random traffic shaping
  logic [15:0] gen_frame;
  logic        gen_lim;
  logic [7:0]  gen_bright;
  int          gen_src;
  logic [31:0] addr_a, addr_b;
  logic [15:0] port_a, port_b;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit frame_ahead(logic [15:0] cand, logic [15:0] base);
    logic [15:0] d;
    d = cand - base;
    return (d != 16'd0) && (d < NEWER_LIMIT);
  endfunction

  task automatic clear_tracker();
    asm_limit  = ASSEMBLY_TIMEOUT_RST;
    rst_limit  = RESTART_TIMEOUT_RST;
    bld_active = 1'b0;
    bld_frame  = '0;
    bld_addr   = '0;
    bld_port   = '0;
    bld_lim    = 1'b0;
    bld_bright = '0;
    bld_mask   = '0;
    bld_count  = '0;
    bld_age    = '0;
    has_done   = 1'b0;
    done_frame = '0;
    done_addr  = '0;
    done_port  = '0;
    done_valid = 1'b0;
    idle_ticks = '0;
  endtask

  task automatic open_frame(input beat_t b);
    bld_active = 1'b1;
    bld_frame  = b.frame;
    bld_addr   = b.addr;
    bld_port   = b.port;
    bld_lim    = b.lim;
    bld_bright = b.bright;
    bld_mask   = '0;
    bld_count  = '0;
    bld_age    = '0;
  endtask

  task automatic take_packet(input beat_t b, output int n);
    result_t r;
    bit      same_src;
    bit      restarted;
    n = 0;
    if (!b.ok || b.frag >= FRAGS) return;
    if (!bld_active) begin
      same_src  = done_valid && done_addr == b.addr && done_port == b.port;
      restarted = has_done && idle_ticks >= rst_limit;
      if (has_done && same_src && !restarted && !frame_ahead(b.frame, done_frame)) return;
      open_frame(b);
    end else if (bld_addr != b.addr || bld_port != b.port) begin
      open_frame(b);
    end else if (b.frame != bld_frame) begin
      if (!frame_ahead(b.frame, bld_frame)) return;
      open_frame(b);
    end
    if (b.lim != bld_lim || b.bright != bld_bright) begin
      bld_active = 1'b0;
      return;
    end
    if (bld_mask[b.frag]) return;
    bld_mask[b.frag] = 1'b1;
    bld_count = bld_count + 4'd1;
    r = '0;
    r.ack_kind       = ACK_FRAGMENT;
    r.ack_frame      = b.frame;
    r.ack_fragment   = b.frag;
    r.received_count = bld_count;
    r.write_payload  = 1'b1;
    r.last           = (bld_mask != '1);
    acks_due.push_back(r);
    n = 1;
    if (bld_mask != '1) return;
    r.received_count = 4'(FRAGS);
    r.write_payload  = 1'b0;
    r.last           = 1'b1;
    if (b.commit) begin
      r.ack_kind          = ACK_COMPLETE;
      r.commit_frame      = 1'b1;
      r.commit_limit      = bld_lim;
      r.commit_brightness = bld_bright;
      has_done   = 1'b1;
      done_frame = b.frame;
      idle_ticks = '0;
      done_addr  = bld_addr;
      done_port  = bld_port;
      done_valid = 1'b1;
    end else begin
      r.ack_kind = ACK_DROPPED;
    end
    acks_due.push_back(r);
    n = 2;
    bld_active = 1'b0;
  endtask

  task automatic track_beat(input beat_t b, output int n);
    n = 0;
    if (b.mode == MODE_TICK) begin
      if (bld_active && bld_age != AGE_MAX) bld_age = bld_age + 16'd1;
      if (idle_ticks != AGE_MAX) idle_ticks = idle_ticks + 16'd1;
    end else begin
      take_packet(b, n);
    end
    if (bld_active && bld_age > asm_limit) bld_active = 1'b0;
  endtask

  function automatic beat_t any_beat();
    beat_t b;
    b.mode   = 1'($urandom_range(0, 1));
    b.ok     = 1'($urandom_range(0, 1));
    b.addr   = $urandom;
    b.port   = 16'($urandom_range(0, 65535));
    b.frame  = 16'($urandom_range(0, 65535));
    b.frag   = 3'($urandom_range(0, 7));
    b.lim    = 1'($urandom_range(0, 1));
    b.bright = 8'($urandom_range(0, 255));
    b.commit = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // mostly well-formed fragments of a moving frame from a sticky sender
  function automatic beat_t next_beat();
    beat_t b;
    int    pick;
    b = any_beat();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      b.mode = MODE_TICK;
      return b;
    end
    b.mode = MODE_PACKET;
    if (pick < 25) begin
      if ($urandom_range(0, 1) == 1) b.frame = gen_frame - 16'($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 1) begin
        b.addr = addr_a;
        b.port = port_a;
      end
      return b;
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 9))
        0:       gen_frame = gen_frame + 16'($urandom_range(1, 16'h7FFF));
        1:       gen_frame = gen_frame - 16'($urandom_range(1, 16'h8000));
        default: gen_frame = gen_frame + 16'd1;
      endcase
      gen_lim    = 1'($urandom_range(0, 1));
      gen_bright = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 6) == 0) gen_src = $urandom_range(0, 2);
    if (gen_src == 0) begin
      b.addr = addr_a;
      b.port = port_a;
    end else if (gen_src == 1) begin
      b.addr = addr_b;
      b.port = port_b;
    end
    b.ok     = ($urandom_range(0, 19) != 0);
    b.frag   = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(FRAGS, 7))
                                            : 3'($urandom_range(0, FRAGS - 1));
    b.frame  = gen_frame;
    b.lim    = gen_lim;
    b.bright = gen_bright;
    b.commit = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 24) == 0) b.bright = b.bright ^ (8'd1 << $urandom_range(0, 7));
    return b;
  endfunction

  task automatic send(input beat_t b, output int n);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end else begin
      gap = ($urandom_range(0, 15) == 0) ? 1 : 0;
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_mode           <= b.mode;
    in_packet_ok      <= b.ok;
    in_source_addr    <= b.addr;
    in_source_port    <= b.port;
    in_frame_number   <= b.frame;
    in_fragment_index <= b.frag;
    in_limit_flag     <= b.lim;
    in_brightness     <= b.bright;
    in_commit_ok      <= b.commit;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_stall);
    track_beat(b, n);
  endtask

  task automatic load_limits(input logic [15:0] asm_v, input logic [15:0] rst_v);
    cfg_index <= CFG_ASSEMBLY_TIMEOUT;
    cfg_data  <= asm_v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    asm_limit = asm_v;
    cfg_index <= CFG_RESTART_TIMEOUT;
    cfg_data  <= rst_v;
    do @(posedge clk); while (!cfg_ready);
    rst_limit = rst_v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (acks_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic string show(result_t r);
    return $sformatf("kind=%0d frame=%h frag=%0d count=%0d wr=%b commit=%b lim=%b bright=%h last=%b",
                     r.ack_kind, r.ack_frame, r.ack_fragment, r.received_count,
                     r.write_payload, r.commit_frame, r.commit_limit,
                     r.commit_brightness, r.last);
  endfunction

  function automatic string diff_fields(result_t want, result_t got);
    string s;
    s = "";
    if (got.ack_kind !== want.ack_kind) s = {s, " ack_kind"};
    if (got.ack_frame !== want.ack_frame) s = {s, " ack_frame"};
    if (got.ack_fragment !== want.ack_fragment) s = {s, " ack_fragment"};
    if (got.received_count !== want.received_count) s = {s, " received_count"};
    if (got.write_payload !== want.write_payload) s = {s, " write_payload"};
    if (got.commit_frame !== want.commit_frame) s = {s, " commit_frame"};
    if (got.commit_limit !== want.commit_limit) s = {s, " commit_limit"};
    if (got.commit_brightness !== want.commit_brightness) s = {s, " commit_brightness"};
    if (got.last !== want.last) s = {s, " last"};
    return s;
  endfunction

  task automatic flag(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s\n  exp %s\n  got %s", $time, what, show(want), show(got));
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    string   bad;
    cycle_cnt++;
    if (rst_n && out_valid && !out_stall) begin
      got.ack_kind          = ack_kind_t'(out_ack_kind);
      got.ack_frame         = out_ack_frame;
      got.ack_fragment      = out_ack_fragment;
      got.received_count    = out_received_count;
      got.write_payload     = out_write_payload;
      got.commit_frame      = out_commit_frame;
      got.commit_limit      = out_commit_limit;
      got.commit_brightness = out_commit_brightness;
      got.last              = out_last;
      if (acks_due.size() == 0) begin
        flag("ack beat with nothing expected", '0, got);
      end else begin
        want = acks_due.pop_front();
        bad = diff_fields(want, got);
        if (bad != "") flag({"ack beat mismatch:", bad}, want, got);
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 128);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= (cycle_cnt % 5 < 2);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int    n;
    int    run;
    beat_t b;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_ASSEMBLY_TIMEOUT;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_mode           = MODE_PACKET;
    in_packet_ok      = 1'b0;
    in_source_addr    = '0;
    in_source_port    = '0;
    in_frame_number   = '0;
    in_fragment_index = '0;
    in_limit_flag     = 1'b0;
    in_brightness     = '0;
    in_commit_ok      = 1'b0;
    out_stall         = 1'b0;
    clear_tracker();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send(dir_tab[i].beat, n);
      if (dir_tab[i].typed &&
          (n != dir_tab[i].n || (n > 0 && acks_due[$].ack_kind != dir_tab[i].kind))) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t directed row %0d: model gives %0d acks, table lists %0d %s",
                   $time, i, n, dir_tab[i].n, dir_tab[i].kind.name());
      end
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       ;
        1:       load_limits(16'd1, 16'd1);
        2:       load_limits(16'hFFFF, 16'hFFFF);
        3:       load_limits(16'hFFFF, 16'd1);
        4:       load_limits(16'd1, 16'hFFFF);
        5:       load_limits(16'($urandom_range(2, 20)), 16'($urandom_range(2, 30)));
        6:       load_limits(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        7:       load_limits(ASSEMBLY_TIMEOUT_RST, RESTART_TIMEOUT_RST);
        default: load_limits(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
      endcase
      addr_a     = $urandom;
      port_a     = 16'($urandom_range(0, 65535));
      addr_b     = $urandom;
      port_b     = 16'($urandom_range(0, 65535));
      gen_frame  = 16'($urandom_range(0, 65535));
      gen_lim    = 1'($urandom_range(0, 1));
      gen_bright = 8'($urandom_range(0, 255));
      gen_src    = 0;
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) == 0) begin
          run = $urandom_range(1, 140);
          repeat (run) begin
            b = any_beat();
            b.mode = MODE_TICK;
            send(b, n);
          end
        end
        send(next_beat(), n);
      end
      drain();
    end

    if (mismatches == 0 && acks_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: frame_packet_reassembly_tracker_core.f
hdl/frpt_pkg.sv
hdl/frame_packet_reassembly_tracker_core.sv
sim/frame_packet_reassembly_tracker_core_test.sv
